>>> hdl/rsi_pkg.sv
// Shared types and constants for the RSI threshold trade signal block.
`default_nettype none
package rsi_pkg;

    localparam int unsigned TICKER_W  = 6;
    localparam int unsigned PRICE_W   = 32;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned MEAN_W    = 48;
    localparam int unsigned THR_W     = 14;
    localparam int unsigned WARM_W    = 8;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARMUP = 2'd0,
        CFG_UPPER  = 2'd1,
        CFG_LOWER  = 2'd2,
        CFG_BET    = 2'd3
    } t_cfg_idx;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SELL = 2'd2;

    // 0.1 price units in Q.16
    localparam logic [MEAN_W-1:0] FALL_EPS = 48'd6554;
    localparam logic [THR_W-1:0]  RSI_FULL = 14'd10000;

    typedef struct packed {
        logic [WARM_W-1:0]  warmup;
        logic [THR_W-1:0]   upper;
        logic [THR_W-1:0]   lower;
        logic [PRICE_W-1:0] bet;
    } t_cfg;

    typedef struct packed {
        logic [TICKER_W-1:0] ticker;
        logic [PRICE_W-1:0]  price;
        logic [PRICE_W-1:0]  shares;
        logic                ign;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [PRICE_W-1:0] prev;
        logic [MEAN_W-1:0]  rise;
        logic [MEAN_W-1:0]  fall;
        logic               buy;
        logic               sell;
    } t_entry;

    typedef struct packed {
        logic [TICKER_W-1:0] ticker;
        logic [ACT_W-1:0]    action;
        logic [PRICE_W-1:0]  amount;
    } t_result;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

>>> hdl/rsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/rsi_div.sv
// Bit-serial restoring divider: 48-bit magnitude by 32-bit divisor, one bit per cycle.
`default_nettype none
module rsi_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rsi_pkg::MEAN_W-1:0]   i_dividend,
    input  wire logic [rsi_pkg::COUNT_W-1:0]  i_divisor,
    output logic      [rsi_pkg::MEAN_W-1:0]   o_quotient,
    output logic                              o_done
);
    localparam int unsigned MW = rsi_pkg::MEAN_W;
    localparam int unsigned DW = rsi_pkg::COUNT_W;
    localparam int unsigned CW = $clog2(MW);
    localparam logic [CW-1:0] LAST = CW'(MW - 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   w_sh;
    logic [DW+1:0] w_trial;
    logic          w_bit;
    logic [DW-1:0] w_rem;

    always_comb begin
        w_sh    = {r_rem, r_quo[MW-1]};
        w_trial = {1'b0, w_sh} - {2'b00, r_div};
        w_bit   = !w_trial[DW+1];
        w_rem   = w_bit ? w_trial[DW-1:0] : w_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MW-2:0], w_bit};
            r_rem <= w_rem;
        end
    end

    assign o_quotient = r_quo;
endmodule
`default_nettype wire

>>> hdl/rsi_front.sv
// Front end: accepts quotes, flags the ones to ignore, holds them in a two-entry queue.
`default_nettype none
module rsi_front #(
    parameter int unsigned TICKERS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [rsi_pkg::TICKER_W-1:0]  i_ticker_index,
    input  wire logic [rsi_pkg::PRICE_W-1:0]   i_close_price,
    input  wire logic [rsi_pkg::PRICE_W-1:0]   i_shares_held,
    output logic                               o_full,
    output logic                               o_valid,
    output rsi_pkg::t_item                     o_item,
    input  wire logic                          i_pop
);
    rsi_pkg::t_item r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    rsi_pkg::t_item w_new;

    always_comb begin
        w_new.ticker = i_ticker_index;
        w_new.price  = i_close_price;
        w_new.shares = i_shares_held;
        w_new.ign    = (i_close_price == '0) || (32'(i_ticker_index) >= TICKERS);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end
endmodule
`default_nettype wire

>>> hdl/rsi_back.sv
// Back end: per-ticker state update, RSI threshold decision and result queue.
`default_nettype none
module rsi_back #(
    parameter int unsigned TICKERS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  rsi_pkg::t_cfg                      i_cfg,
    input  wire logic                          i_mid_valid,
    input  rsi_pkg::t_item                     i_mid_item,
    output logic                               o_mid_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [rsi_pkg::TICKER_W-1:0]       o_ticker_out,
    output logic [rsi_pkg::ACT_W-1:0]          o_action,
    output logic [rsi_pkg::PRICE_W-1:0]        o_order_amount
);
    localparam int unsigned AW = (TICKERS > 1) ? $clog2(TICKERS) : 1;
    localparam int unsigned MW = rsi_pkg::MEAN_W;
    localparam int unsigned PW = rsi_pkg::PRICE_W;
    localparam int unsigned TW = rsi_pkg::THR_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr_addr;
    rsi_pkg::t_item   r_item;
    rsi_pkg::t_entry  r_ent;
    logic             r_rneg;
    logic             r_fneg;
    logic [MW-1:0]    r_new_rise;
    logic [MW-1:0]    r_new_fall;
    logic [MW+TW-1:0] r_pu;
    logic [MW+TW:0]   r_pt;
    logic [MW+TW:0]   r_pl;
    rsi_pkg::t_result r_res;
    rsi_pkg::t_result r_oq [2];
    logic             r_owp;
    logic             r_orp;
    logic [1:0]       r_ocnt;

    rsi_pkg::t_entry  w_rd;
    logic [rsi_pkg::ENTRY_W-1:0] w_rdata;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    rsi_pkg::t_entry  w_wdata;
    logic [AW-1:0]    w_raddr;

    logic             w_up;
    logic [PW-1:0]    w_move;
    logic [MW:0]      w_rdiff;
    logic [MW:0]      w_fdiff;
    logic [MW:0]      w_rmag;
    logic [MW:0]      w_fmag;
    logic             w_div_start;
    logic [MW-1:0]    w_rquo;
    logic [MW-1:0]    w_fquo;
    logic             w_rdone;
    logic             w_fdone;
    logic [MW:0]      w_total;
    logic             w_near;
    logic             w_above;
    logic             w_below;
    logic             w_warm;
    rsi_pkg::t_entry  w_upd;
    rsi_pkg::t_result w_dec;
    logic             w_opush;
    logic             w_opop;

    assign w_rd    = rsi_pkg::t_entry'(w_rdata);
    assign w_raddr = AW'(i_mid_item.ticker);

    rsi_ram #(.WIDTH(rsi_pkg::ENTRY_W), .DEPTH(TICKERS)) u_state (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // move goes wholly to rise or fall; diff = (move << 16) - mean
    always_comb begin
        w_up    = r_item.price > w_rd.prev;
        w_move  = w_up ? (r_item.price - w_rd.prev) : (w_rd.prev - r_item.price);
        w_rdiff = {1'b0, (w_up ? w_move : '0), 16'h0} - {1'b0, w_rd.rise};
        w_fdiff = {1'b0, (w_up ? '0 : w_move), 16'h0} - {1'b0, w_rd.fall};
        w_rmag  = w_rdiff[MW] ? (~w_rdiff + 1'b1) : w_rdiff;
        w_fmag  = w_fdiff[MW] ? (~w_fdiff + 1'b1) : w_fdiff;
        w_div_start = (r_state == S_LOAD) && (w_rd.cnt != '0);
    end

    rsi_div u_div_rise (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rmag[MW-1:0]),
        .i_divisor  (w_rd.cnt),
        .o_quotient (w_rquo),
        .o_done     (w_rdone)
    );

    rsi_div u_div_fall (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_fmag[MW-1:0]),
        .i_divisor  (w_rd.cnt),
        .o_quotient (w_fquo),
        .o_done     (w_fdone)
    );

    always_comb begin
        w_total = {1'b0, r_new_rise} + {1'b0, r_new_fall};
        w_near  = r_new_fall < rsi_pkg::FALL_EPS;
        w_above = w_near ? (rsi_pkg::RSI_FULL > i_cfg.upper) : ({1'b0, r_pu} > r_pt);
        w_below = w_near ? (rsi_pkg::RSI_FULL < i_cfg.lower) : ({1'b0, r_pu} < r_pl);
        w_warm  = r_ent.cnt >= 32'(i_cfg.warmup);

        w_upd.cnt  = (&r_ent.cnt) ? r_ent.cnt : r_ent.cnt + 1'b1;
        w_upd.prev = r_item.price;
        w_upd.rise = r_new_rise;
        w_upd.fall = r_new_fall;
        w_upd.buy  = r_ent.buy;
        w_upd.sell = r_ent.sell;
        w_dec.ticker = r_item.ticker;
        w_dec.action = rsi_pkg::ACT_NONE;
        w_dec.amount = '0;
        if (w_warm) begin
            priority if (w_above) begin
                if (r_ent.buy && (r_item.shares == '0)) begin
                    w_dec.action = rsi_pkg::ACT_BUY;
                    w_dec.amount = i_cfg.bet;
                end
                w_upd.buy  = 1'b0;
                w_upd.sell = 1'b1;
            end else if (w_below) begin
                if (r_ent.sell && (r_item.shares != '0)) begin
                    w_dec.action = rsi_pkg::ACT_SELL;
                    w_dec.amount = r_item.shares;
                end
                w_upd.sell = 1'b0;
                w_upd.buy  = 1'b1;
            end else begin
                w_upd.buy  = 1'b1;
                w_upd.sell = 1'b1;
            end
        end
    end

    // state store write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_item.ticker);
        w_wdata = w_upd;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_LOAD: begin
                w_we         = (w_rd.cnt == '0);
                w_wdata      = w_rd;
                w_wdata.cnt  = 32'd1;
                w_wdata.prev = r_item.price;
            end
            S_CMP: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_mid_pop = (r_state == S_IDLE) && i_mid_valid && (r_ocnt != 2'd2);
    assign w_opush   = (r_state == S_OUT);
    assign w_opop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(TICKERS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_mid_pop) r_state <= i_mid_item.ign ? S_OUT : S_LOAD;
                end
                S_LOAD: begin
                    r_state <= (w_rd.cnt == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    if (w_rdone) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item       <= i_mid_item;
                r_res.ticker <= i_mid_item.ticker;
                r_res.action <= rsi_pkg::ACT_NONE;
                r_res.amount <= '0;
            end
            S_LOAD: begin
                r_ent  <= w_rd;
                r_rneg <= w_rdiff[MW];
                r_fneg <= w_fdiff[MW];
            end
            S_DIV: begin
                if (w_fdone) begin
                    r_new_rise <= r_ent.rise + (r_rneg ? (~w_rquo + 1'b1) : w_rquo);
                    r_new_fall <= r_ent.fall + (r_fneg ? (~w_fquo + 1'b1) : w_fquo);
                end
            end
            S_MUL: begin
                r_pu <= (MW+TW)'(r_new_rise) * (MW+TW)'(rsi_pkg::RSI_FULL);
                r_pt <= (MW+TW+1)'(w_total) * (MW+TW+1)'(i_cfg.upper);
                r_pl <= (MW+TW+1)'(w_total) * (MW+TW+1)'(i_cfg.lower);
            end
            S_CMP: begin
                r_res <= w_dec;
            end
            default: begin
            end
        endcase
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_opush) r_owp <= !r_owp;
            if (w_opop)  r_orp <= !r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= r_res;
        end
    end

    assign o_empty        = (r_ocnt == 2'd0);
    assign o_ticker_out   = r_oq[r_orp].ticker;
    assign o_action       = r_oq[r_orp].action;
    assign o_order_amount = r_oq[r_orp].amount;
endmodule
`default_nettype wire

>>> hdl/rsi_threshold_trade_signal.sv
// Top level of the RSI threshold trade signal block.
`default_nettype none
// Per-ticker RSI threshold trader. Every accepted quote yields exactly one result, in
// order. After reset the per-ticker state store is cleared one entry a cycle, every
// entry, before the first quote is processed (quotes queue up meanwhile). In the back
// end an ignored quote (zero price or ticker out of range) goes from idle to output, a
// first sample of a ticker through load to output, and a later sample through load,
// divide (two bit-serial 48-step mean-update dividers side by side), multiply,
// compare and output. A two-entry queue per side lets input and result stall independently.
module rsi_threshold_trade_signal #(
    parameter int unsigned TICKERS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rsi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rsi_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [rsi_pkg::TICKER_W-1:0]    i_ticker_index,
    input  wire logic [rsi_pkg::PRICE_W-1:0]     i_close_price,
    input  wire logic [rsi_pkg::PRICE_W-1:0]     i_shares_held,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [rsi_pkg::TICKER_W-1:0]         o_ticker_out,
    output logic [rsi_pkg::ACT_W-1:0]            o_action,
    output logic [rsi_pkg::PRICE_W-1:0]          o_order_amount
);
    rsi_pkg::t_cfg  r_cfg;
    logic           w_mid_valid;
    logic           w_mid_pop;
    rsi_pkg::t_item w_mid_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup <= 8'd5;
            r_cfg.upper  <= 14'd5001;
            r_cfg.lower  <= 14'd4999;
            r_cfg.bet    <= '0;
        end else if (i_cfg_we) begin
            unique case (rsi_pkg::t_cfg_idx'(i_cfg_index))
                rsi_pkg::CFG_WARMUP: r_cfg.warmup <= i_cfg_data[rsi_pkg::WARM_W-1:0];
                rsi_pkg::CFG_UPPER:  r_cfg.upper  <= i_cfg_data[rsi_pkg::THR_W-1:0];
                rsi_pkg::CFG_LOWER:  r_cfg.lower  <= i_cfg_data[rsi_pkg::THR_W-1:0];
                rsi_pkg::CFG_BET:    r_cfg.bet    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsi_front #(.TICKERS(TICKERS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_ticker_index (i_ticker_index),
        .i_close_price  (i_close_price),
        .i_shares_held  (i_shares_held),
        .o_full         (full),
        .o_valid        (w_mid_valid),
        .o_item         (w_mid_item),
        .i_pop          (w_mid_pop)
    );

    rsi_back #(.TICKERS(TICKERS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_mid_valid    (w_mid_valid),
        .i_mid_item     (w_mid_item),
        .o_mid_pop      (w_mid_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_ticker_out   (o_ticker_out),
        .o_action       (o_action),
        .o_order_amount (o_order_amount)
    );

    a_mid_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> w_mid_valid)
        else $error("back end took an item from an empty front queue");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_action == rsi_pkg::ACT_NONE || o_action == rsi_pkg::ACT_BUY ||
                    o_action == rsi_pkg::ACT_SELL))
        else $error("result carries an undefined action code");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == rsi_pkg::ACT_NONE) |-> (o_order_amount == '0))
        else $error("result with no action carries a nonzero amount");

    a_sell_shares: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == rsi_pkg::ACT_SELL) |-> (o_order_amount != '0))
        else $error("sell order issued with no shares held");

endmodule
`default_nettype wire
